// ----- sv/lfcr_pkg.sv -----
package lfcr_pkg;

    localparam int COLUMNS     = 12;
    localparam int ROWS        = 19;
    localparam int CHUNK_BYTES = 200;
    localparam int MAX_PACKET  = 256;

    localparam int HDR_LEN     = 5;
    localparam int LED_TOTAL   = COLUMNS * ROWS;
    localparam int FRAME_BYTES = LED_TOTAL * 3;
    localparam int MAX_CHUNKS  = (FRAME_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;

    localparam int LED_W  = $clog2(LED_TOTAL + 1);
    localparam int FB_AW  = $clog2(FRAME_BYTES);
    localparam int FB_CW  = $clog2(FRAME_BYTES + 1);
    localparam int POS_W  = $clog2(MAX_PACKET + 2);
    localparam int ST_AW  = $clog2(MAX_PACKET);
    localparam int CH_W   = $clog2(MAX_CHUNKS);
    localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int OFF_W  = $clog2(MAX_CHUNKS * CHUNK_BYTES + 1);
    localparam int SUM_W  = ((OFF_W > 16) ? OFF_W : 16) + 1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [7:0] pixel_index;
    } t_req;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] packet_total;
        logic [31:0] frame_total;
    } t_res;

    typedef enum logic [2:0] {
        ST_SHORT     = 3'd0,
        ST_TOO_LONG  = 3'd1,
        ST_BAD_COUNT = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_UNWRITTEN = 3'd5,
        ST_STORED    = 3'd6,
        ST_SHOWN     = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_COPY,
        S_DECIDE,
        S_SHOW,
        S_PIXEL
    } t_state;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

endpackage

// ----- sv/lfcr_ram.sv -----
module lfcr_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/led_frame_chunk_reassembler_core.sv -----
// channel  | signals                     | direction | request accepted when
// ---------+-----------------------------+-----------+----------------------------
// request  | i_start, i_req, o_busy      | in        | i_start high, o_busy low
// result   | o_strobe, o_result          | out       | o_strobe high, one cycle only
//
// a packet byte that is not the last leaves the block idle; a pixel read waits for the
// registered display memory read (S_PIXEL). a packet end passes S_EVAL, S_COPY and
// S_DECIDE for a chunk to store, S_SHOW when the frame is shown (one frame memory
// read a cycle). after reset a clearing pass over the frame bytes (684) zeroes frame
// and display memories while busy is high. the result receiver cannot stall the block.
module led_frame_chunk_reassembler_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  lfcr_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_strobe,
    output lfcr_pkg::t_res o_result
);
    import lfcr_pkg::*;

    t_state r_state, n_state;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_len, n_len;
    logic [7:0]        r_hdr [HDR_LEN];
    logic              hdr_we;
    logic [7:0]        r_cur_frame, n_cur_frame;
    logic [CNT_W-1:0]  r_exp_cnt, n_exp_cnt;
    logic [CNT_W-1:0]  r_seen_cnt, n_seen_cnt;
    logic [MAX_CHUNKS-1:0] r_seen, n_seen;
    logic [31:0]       r_packets, n_packets;
    logic [31:0]       r_frames, n_frames;
    logic [FB_CW-1:0]  r_clr, n_clr;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [POS_W-1:0]  r_clen, n_clen;
    logic [POS_W-1:0]  r_i, n_i;
    logic              r_cp_v, n_cp_v;
    logic [FB_AW-1:0]  r_cp_addr, n_cp_addr;
    logic [FB_CW-1:0]  r_fa, n_fa;
    logic [1:0]        r_sub, n_sub;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [LED_W-1:0]  r_base, n_base;
    logic              r_sh_v, n_sh_v;
    logic [1:0]        r_sh_sub, n_sh_sub;
    logic [LED_W-1:0]  r_sh_phys, n_sh_phys;
    logic [23:0]       r_rgb, n_rgb;
    logic              r_pix_ok, n_pix_ok;
    logic              r_strobe, n_strobe;
    t_res              r_res, n_res;

    logic              st_we;
    logic [ST_AW-1:0]  st_waddr, st_raddr;
    logic [7:0]        st_rdata;
    logic              fb_we;
    logic [FB_AW-1:0]  fb_waddr, fb_raddr;
    logic [7:0]        fb_wdata, fb_rdata;
    logic              dp_we;
    logic [LED_W-1:0]  dp_waddr, dp_raddr;
    logic [23:0]       dp_wdata, dp_rdata;

    logic [POS_W-1:0]  pos_inc;
    logic [7:0]        h_cnt;
    logic [7:0]        h_idx;
    logic [15:0]       h_clen;
    logic [CH_W-1:0]   idx_s;
    logic              renew;
    logic [MAX_CHUNKS-1:0] seen_base;
    logic [CNT_W-1:0]  seen_cnt_base;
    logic [OFF_W-1:0]  off_c;
    logic [LED_W-1:0]  phys;

    lfcr_ram #(.DEPTH(MAX_PACKET), .WIDTH(8)) u_stage (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (i_req.data_byte),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    lfcr_ram #(.DEPTH(FRAME_BYTES), .WIDTH(8)) u_frame (
        .i_clk   (i_clk),
        .i_we    (fb_we),
        .i_waddr (fb_waddr),
        .i_wdata (fb_wdata),
        .i_raddr (fb_raddr),
        .o_rdata (fb_rdata)
    );

    lfcr_ram #(.DEPTH(LED_TOTAL), .WIDTH(24)) u_disp (
        .i_clk   (i_clk),
        .i_we    (dp_we),
        .i_waddr (dp_waddr),
        .i_wdata (dp_wdata),
        .i_raddr (dp_raddr),
        .o_rdata (dp_rdata)
    );

    assign h_idx  = r_hdr[1];
    assign h_cnt  = r_hdr[2];
    assign h_clen = {r_hdr[4], r_hdr[3]};
    assign idx_s  = CH_W'(h_idx);
    assign off_c  = OFF_W'(idx_s) * OFF_W'(CHUNK_BYTES);
    assign phys   = r_col[0] ? (r_base + LED_W'(ROWS - 1) - LED_W'(r_row))
                             : (r_base + LED_W'(r_row));
    assign pos_inc = (r_pos <= POS_W'(MAX_PACKET)) ? (r_pos + 1'b1) : r_pos;
    assign renew  = (h_cnt != 8'(r_exp_cnt)) || (r_hdr[0] != r_cur_frame);
    assign seen_base     = renew ? '0 : r_seen;
    assign seen_cnt_base = renew ? '0 : r_seen_cnt;

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[r_pos[2:0]] <= i_req.data_byte;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_len       = r_len;
        n_cur_frame = r_cur_frame;
        n_exp_cnt   = r_exp_cnt;
        n_seen_cnt  = r_seen_cnt;
        n_seen      = r_seen;
        n_packets   = r_packets;
        n_frames    = r_frames;
        n_clr       = r_clr;
        n_off       = r_off;
        n_clen      = r_clen;
        n_i         = r_i;
        n_cp_v      = 1'b0;
        n_cp_addr   = r_cp_addr;
        n_fa        = r_fa;
        n_sub       = r_sub;
        n_row       = r_row;
        n_col       = r_col;
        n_base      = r_base;
        n_sh_v      = 1'b0;
        n_sh_sub    = r_sh_sub;
        n_sh_phys   = r_sh_phys;
        n_rgb       = r_rgb;
        n_pix_ok    = r_pix_ok;
        n_strobe    = 1'b0;
        n_res       = '0;
        o_busy      = 1'b1;
        hdr_we      = 1'b0;
        st_we       = 1'b0;
        st_waddr    = ST_AW'(r_pos);
        st_raddr    = ST_AW'(POS_W'(HDR_LEN) + r_i);
        fb_we       = r_cp_v;
        fb_waddr    = r_cp_addr;
        fb_wdata    = st_rdata;
        fb_raddr    = FB_AW'(r_fa);
        dp_we       = r_sh_v && (r_sh_sub == 2'd2);
        dp_waddr    = r_sh_phys;
        dp_wdata    = {r_rgb[23:8], fb_rdata};
        dp_raddr    = '0;

        if (r_sh_v) begin
            case (r_sh_sub)
                2'd0:    n_rgb[23:16] = fb_rdata;
                2'd1:    n_rgb[15:8]  = fb_rdata;
                default: n_rgb        = r_rgb;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                fb_we    = 1'b1;
                fb_waddr = FB_AW'(r_clr);
                fb_wdata = '0;
                dp_we    = (r_clr < FB_CW'(LED_TOTAL));
                dp_waddr = LED_W'(r_clr);
                dp_wdata = '0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == FB_CW'(FRAME_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_req.action == KIND_PIXEL) begin
                        n_pix_ok = (16'(i_req.pixel_index) < 16'(LED_TOTAL));
                        dp_raddr = n_pix_ok ? LED_W'(i_req.pixel_index) : '0;
                        n_state  = S_PIXEL;
                    end else begin
                        st_we  = (r_pos < POS_W'(MAX_PACKET));
                        hdr_we = (r_pos < POS_W'(HDR_LEN));
                        if (i_req.last_byte) begin
                            n_len   = pos_inc;
                            n_pos   = '0;
                            n_state = S_EVAL;
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                n_res.kind = KIND_PACKET;
                if (r_len < POS_W'(HDR_LEN)) begin
                    n_strobe     = 1'b1;
                    n_res.status = ST_SHORT;
                end else begin
                    n_packets = r_packets + 32'd1;
                    n_strobe  = 1'b1;
                    if (r_len > POS_W'(MAX_PACKET)) begin
                        n_res.status = ST_TOO_LONG;
                    end else if (h_cnt == 8'd0 || 16'(h_cnt) > 16'(MAX_CHUNKS)) begin
                        n_res.status = ST_BAD_COUNT;
                    end else if (h_idx >= h_cnt) begin
                        n_res.status = ST_BAD_INDEX;
                    end else if (17'(r_len) < 17'(HDR_LEN) + 17'(h_clen)) begin
                        n_res.status = ST_TRUNCATED;
                    end else begin
                        n_cur_frame = r_hdr[0];
                        n_exp_cnt   = CNT_W'(h_cnt);
                        n_seen      = seen_base;
                        n_seen_cnt  = seen_cnt_base;
                        if (!seen_base[idx_s]) begin
                            n_seen[idx_s] = 1'b1;
                            n_seen_cnt    = seen_cnt_base + 1'b1;
                        end
                        if (SUM_W'(off_c) + SUM_W'(h_clen) > SUM_W'(FRAME_BYTES)) begin
                            n_res.status = ST_UNWRITTEN;
                        end else begin
                            n_strobe = 1'b0;
                            n_off    = off_c;
                            n_clen   = POS_W'(h_clen);
                            n_i      = '0;
                            n_state  = S_COPY;
                        end
                    end
                end
            end
            S_COPY: begin
                if (r_i != r_clen) begin
                    n_cp_v    = 1'b1;
                    n_cp_addr = FB_AW'(r_off + OFF_W'(r_i));
                    n_i       = r_i + 1'b1;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_seen_cnt >= r_exp_cnt) begin
                    n_fa    = '0;
                    n_sub   = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_base  = '0;
                    n_state = S_SHOW;
                end else begin
                    n_strobe     = 1'b1;
                    n_res.kind   = KIND_PACKET;
                    n_res.status = ST_STORED;
                    n_state      = S_IDLE;
                end
            end
            S_SHOW: begin
                if (r_fa != FB_CW'(FRAME_BYTES)) begin
                    n_sh_v    = 1'b1;
                    n_sh_sub  = r_sub;
                    n_sh_phys = phys;
                    n_fa      = r_fa + 1'b1;
                    if (r_sub == 2'd2) begin
                        n_sub = '0;
                        if (r_row == ROW_W'(ROWS - 1)) begin
                            n_row  = '0;
                            n_col  = r_col + 1'b1;
                            n_base = r_base + LED_W'(ROWS);
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end else begin
                    n_frames     = r_frames + 32'd1;
                    n_strobe     = 1'b1;
                    n_res.kind   = KIND_PACKET;
                    n_res.status = ST_SHOWN;
                    n_state      = S_IDLE;
                end
            end
            S_PIXEL: begin
                n_strobe    = 1'b1;
                n_res.kind  = KIND_PIXEL;
                n_res.red   = r_pix_ok ? dp_rdata[23:16] : 8'd0;
                n_res.green = r_pix_ok ? dp_rdata[15:8]  : 8'd0;
                n_res.blue  = r_pix_ok ? dp_rdata[7:0]   : 8'd0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.packet_total = n_packets;
        n_res.frame_total  = n_frames;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_cur_frame <= '0;
            r_exp_cnt   <= '0;
            r_seen_cnt  <= '0;
            r_seen      <= '0;
            r_packets   <= '0;
            r_frames    <= '0;
            r_clr       <= '0;
            r_cp_v      <= 1'b0;
            r_sh_v      <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_cur_frame <= n_cur_frame;
            r_exp_cnt   <= n_exp_cnt;
            r_seen_cnt  <= n_seen_cnt;
            r_seen      <= n_seen;
            r_packets   <= n_packets;
            r_frames    <= n_frames;
            r_clr       <= n_clr;
            r_cp_v      <= n_cp_v;
            r_sh_v      <= n_sh_v;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len     <= n_len;
        r_off     <= n_off;
        r_clen    <= n_clen;
        r_i       <= n_i;
        r_cp_addr <= n_cp_addr;
        r_fa      <= n_fa;
        r_sub     <= n_sub;
        r_row     <= n_row;
        r_col     <= n_col;
        r_base    <= n_base;
        r_sh_sub  <= n_sh_sub;
        r_sh_phys <= n_sh_phys;
        r_rgb     <= n_rgb;
        r_pix_ok  <= n_pix_ok;
        r_res     <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    a_pixel_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.kind == KIND_PIXEL |-> o_result.status == ST_SHORT)
        else $error("pixel answer carries a status");

    a_packet_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.kind == KIND_PACKET
        |-> o_result.red == 8'd0 && o_result.green == 8'd0 && o_result.blue == 8'd0)
        else $error("packet status carries a color");

    a_shown_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.kind == KIND_PACKET && o_result.status == ST_SHOWN
        |-> r_frames == $past(r_frames) + 32'd1)
        else $error("frame shown without frame count update");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> o_busy && !o_strobe)
        else $error("request possible during clearing pass");

endmodule
